// ----- rtl/rgn_pkg.sv -----
// ============================================================================
// rgn_pkg
// Shared widths, status codes and request/response types for the rational
// GCD normalizer.
// ============================================================================
package rgn_pkg;

    localparam int IN_WIDTH  = 64;
    localparam int OUT_WIDTH = 32;
    localparam int CMP_WIDTH = ((IN_WIDTH > OUT_WIDTH) ? IN_WIDTH : OUT_WIDTH) + 1;

    localparam logic [CMP_WIDTH-1:0] INT_MIN_MAG = CMP_WIDTH'(1) << (OUT_WIDTH - 1);
    localparam logic [CMP_WIDTH-1:0] INT_MAX     = INT_MIN_MAG - CMP_WIDTH'(1);

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_ZERO_DEN = 2'd1,
        STATUS_RANGE    = 2'd2
    } status_t;

    typedef struct packed {
        logic signed [IN_WIDTH-1:0] numerator_in;
        logic signed [IN_WIDTH-1:0] denominator_in;
    } req_t;

    typedef struct packed {
        status_t                     status;
        logic signed [OUT_WIDTH-1:0] numerator_out;
        logic [OUT_WIDTH-2:0]        denominator_out;
    } rsp_t;

endpackage

// ----- rtl/rational_gcd_normalizer.sv -----
// ============================================================================
// rational_gcd_normalizer
// Reduces a signed fraction to lowest terms with a positive denominator.
// ============================================================================
// Usage:
//   Request channel (req_valid / req_stall / req) carries a signed numerator
//   and denominator. Response channel (rsp_valid / rsp_stall / rsp) returns
//   one status, reduced numerator and positive reduced denominator per request.
//   Status: ok, zero denominator, or reduced value outside the signed
//   OUT_WIDTH range (values are zero for both error codes).
//   Sequence: setup on acceptance, a binary GCD (one compare/subtract,
//   shift or swap per cycle), then two restoring divisions of IN_WIDTH
//   quotient bits each, then a final step to form the response.
//   The GCD and divisions share one IN_WIDTH-bit subtractor, so one request
//   is in work at a time; req_stall is high from acceptance until the
//   response is loaded. A finished response waits in the output register
//   while rsp_stall is high; the next request is accepted meanwhile and
//   holds in its last step until the output register is free.
//   Reset clears the sequencer and the response valid; no clearing pass.
// ============================================================================
module rational_gcd_normalizer (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  rgn_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output rgn_pkg::rsp_t rsp
);

    localparam int W     = rgn_pkg::IN_WIDTH;
    localparam int CW    = rgn_pkg::CMP_WIDTH;
    localparam int CNT_W = $clog2(W);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_GCD,
        ST_DIVN,
        ST_DIVD,
        ST_FIN
    } state_t;

    state_t             state_reg, state_next;
    logic [W-1:0]       a_reg, a_next;
    logic [W-1:0]       b_reg, b_next;
    logic [W-1:0]       mn_reg, mn_next;
    logic [W-1:0]       md_reg, md_next;
    logic [W-1:0]       rem_reg, rem_next;
    logic [CNT_W-1:0]   k_reg, k_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               nneg_reg, nneg_next;
    logic               dneg_reg, dneg_next;
    logic               zero_reg, zero_next;
    logic               rsp_valid_reg, rsp_valid_next;
    rgn_pkg::rsp_t      rsp_reg, rsp_next;

    logic [W-1:0]       sub_x;
    logic [W-1:0]       sub_y;
    logic [W:0]         diff;
    logic               ge;
    logic [W-1:0]       trial;
    logic [W-1:0]       num_raw;
    logic [W-1:0]       den_raw;
    logic [W-1:0]       num_mag;
    logic [W-1:0]       den_mag;
    logic [CW-1:0]      rn_ext;
    logic [CW-1:0]      rd_ext;
    logic [CW-1:0]      num_val;
    logic               res_neg;
    logic               over;

    assign trial = {rem_reg[W-2:0], a_reg[W-1]};

    always_comb
    begin
        sub_x = a_reg;
        sub_y = b_reg;
        if (state_reg == ST_DIVN || state_reg == ST_DIVD)
        begin
            sub_x = trial;
        end
    end

    assign diff = {1'b0, sub_x} - {1'b0, sub_y};
    assign ge   = !diff[W];

    assign num_raw = $unsigned(req.numerator_in);
    assign den_raw = $unsigned(req.denominator_in);
    assign num_mag = num_raw[W-1] ? (W'(0) - num_raw) : num_raw;
    assign den_mag = den_raw[W-1] ? (W'(0) - den_raw) : den_raw;

    assign rn_ext  = CW'(mn_reg);
    assign rd_ext  = CW'(a_reg);
    assign res_neg = (nneg_reg != dneg_reg) && (mn_reg != '0);
    assign over    = (rd_ext > rgn_pkg::INT_MAX) ||
                     (res_neg ? (rn_ext > rgn_pkg::INT_MIN_MAG)
                              : (rn_ext > rgn_pkg::INT_MAX));
    assign num_val = res_neg ? (CW'(0) - rn_ext) : rn_ext;

    always_comb
    begin
        state_next     = state_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        mn_next        = mn_reg;
        md_next        = md_reg;
        rem_next       = rem_reg;
        k_next         = k_reg;
        cnt_next       = cnt_reg;
        nneg_next      = nneg_reg;
        dneg_next      = dneg_reg;
        zero_next      = zero_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        rsp_next       = rsp_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    mn_next   = num_mag;
                    md_next   = den_mag;
                    a_next    = num_mag;
                    b_next    = den_mag;
                    nneg_next = num_raw[W-1];
                    dneg_next = den_raw[W-1];
                    k_next    = '0;
                    zero_next = (den_mag == '0);
                    state_next = (den_mag == '0) ? ST_FIN : ST_GCD;
                end
            end
            ST_GCD:
            begin
                if (a_reg == '0)
                begin
                    b_next     = W'(b_reg << k_reg);
                    a_next     = mn_reg;
                    rem_next   = '0;
                    cnt_next   = '0;
                    state_next = ST_DIVN;
                end
                else if (!a_reg[0] && !b_reg[0])
                begin
                    a_next = a_reg >> 1;
                    b_next = b_reg >> 1;
                    k_next = k_reg + CNT_W'(1);
                end
                else if (!a_reg[0])
                begin
                    a_next = a_reg >> 1;
                end
                else if (!b_reg[0])
                begin
                    b_next = b_reg >> 1;
                end
                else if (ge)
                begin
                    a_next = diff[W-1:0] >> 1;
                end
                else
                begin
                    a_next = b_reg;
                    b_next = a_reg;
                end
            end
            ST_DIVN, ST_DIVD:
            begin
                rem_next = ge ? diff[W-1:0] : trial;
                a_next   = {a_reg[W-2:0], ge};
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(W - 1))
                begin
                    cnt_next = '0;
                    if (state_reg == ST_DIVN)
                    begin
                        mn_next    = {a_reg[W-2:0], ge};
                        a_next     = md_reg;
                        rem_next   = '0;
                        state_next = ST_DIVD;
                    end
                    else
                    begin
                        state_next = ST_FIN;
                    end
                end
            end
            ST_FIN:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_valid_next = 1'b1;
                    if (zero_reg)
                    begin
                        rsp_next.status          = rgn_pkg::STATUS_ZERO_DEN;
                        rsp_next.numerator_out   = '0;
                        rsp_next.denominator_out = '0;
                    end
                    else if (over)
                    begin
                        rsp_next.status          = rgn_pkg::STATUS_RANGE;
                        rsp_next.numerator_out   = '0;
                        rsp_next.denominator_out = '0;
                    end
                    else
                    begin
                        rsp_next.status          = rgn_pkg::STATUS_OK;
                        rsp_next.numerator_out   = $signed(num_val[rgn_pkg::OUT_WIDTH-1:0]);
                        rsp_next.denominator_out = rd_ext[rgn_pkg::OUT_WIDTH-2:0];
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rsp_valid_reg <= 1'b0;
            rsp_reg       <= '0;
            zero_reg      <= 1'b0;
            k_reg         <= '0;
            cnt_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
            rsp_reg       <= rsp_next;
            zero_reg      <= zero_next;
            k_reg         <= k_next;
            cnt_reg       <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg    <= a_next;
        b_reg    <= b_next;
        mn_reg   <= mn_next;
        md_reg   <= md_next;
        rem_reg  <= rem_next;
        nneg_reg <= nneg_next;
        dneg_reg <= dneg_next;
    end

    assign req_stall = (state_reg != ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    a_gcd_divisor_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_GCD) |-> (b_reg != '0))
        else $error("gcd operand b reached zero");

    a_div_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIVN || state_reg == ST_DIVD) |-> (rem_reg < b_reg))
        else $error("division remainder not below divisor");

    a_ok_den_positive: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.status == rgn_pkg::STATUS_OK) |-> (rsp.denominator_out != '0))
        else $error("ok response with zero denominator");

    a_err_values_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.status != rgn_pkg::STATUS_OK) |->
            (rsp.numerator_out == '0 && rsp.denominator_out == '0))
        else $error("error response carries nonzero values");

endmodule
